>>> src/stu_pkg.sv
// ----------------------------------------------------------------------------
// stu_pkg - shared types and constants of the string-to-unsigned parser
// Holds the request and result payloads, the per-character class record that
// travels from the front end to the converter, and the character decoding.
// ----------------------------------------------------------------------------
`default_nettype none

package stu_pkg;

    // Field widths fixed by the interface
    localparam int CH_W       = 8;
    localparam int BASE_W     = 6;
    localparam int DIGIT_W    = 6;
    localparam int VALUE_W    = 32;
    localparam int CONSUMED_W = 16;
    localparam int STATUS_W   = 2;

    // Queue between front end and converter
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_CONVERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_CONV   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    // Base codes
    localparam logic [BASE_W-1:0] BASE_AUTO    = 6'd0;
    localparam logic [BASE_W-1:0] BASE_INVALID = 6'd1;
    localparam logic [BASE_W-1:0] BASE_OCT     = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC     = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX     = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX     = 6'd36;

    // Digit code for a character that is no digit in any base
    localparam logic [DIGIT_W-1:0] NO_DIGIT = 6'd63;

    // Characters of interest
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5A;
    localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CH_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CH_W-1:0] CH_LO_X  = 8'h78;

    // Input request
    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            start_of_string;
    } t_in_item;

    // Result
    typedef struct packed {
        logic [VALUE_W-1:0]    value;
        logic [CONSUMED_W-1:0] consumed;
        logic [STATUS_W-1:0]   status;
    } t_out_item;

    // Classified character as queued for the converter
    typedef struct packed {
        logic               start;
        logic [BASE_W-1:0]  base;
        logic [DIGIT_W-1:0] digit;
        logic               is_blank;
        logic               is_minus;
        logic               is_plus;
        logic               is_zero;
        logic               is_x;
        logic               is_hex;
    } t_cls;

    // Value of a character as a digit of base up to 36
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CH_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        begin
            d = NO_DIGIT;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = DIGIT_W'(c - CH_ZERO);
            end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
                d = DIGIT_W'(c - CH_UP_A + 8'd10);
            end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
                d = DIGIT_W'(c - CH_LO_A + 8'd10);
            end
            return d;
        end
    endfunction

endpackage

`default_nettype wire

>>> src/stu_front.sv
// ----------------------------------------------------------------------------
// stu_front - request intake and character classifier
// Holds the base register, decodes each accepted character into its class
// record and pushes it into the queue towards the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module stu_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  stu_pkg::t_in_item      i_in_data,
    output logic                   o_in_stall,
    input  wire                    i_cfg_we,
    input  wire [5:0]              i_cfg_data,
    input  wire                    i_full,
    output logic                   o_push,
    output stu_pkg::t_cls          o_cls
);
    import stu_pkg::*;

    logic [BASE_W-1:0]  r_base_select;
    logic [DIGIT_W-1:0] digit;

    // Hold the base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_select <= BASE_AUTO;
        end else if (i_cfg_we) begin
            r_base_select <= i_cfg_data;
        end
    end

    // Classify the character
    always_comb begin
        digit           = digit_of(i_in_data.ch);
        o_cls.start     = i_in_data.start_of_string;
        o_cls.base      = r_base_select;
        o_cls.digit     = digit;
        o_cls.is_blank  = (i_in_data.ch == CH_SPACE) || (i_in_data.ch == CH_TAB);
        o_cls.is_minus  = (i_in_data.ch == CH_MINUS);
        o_cls.is_plus   = (i_in_data.ch == CH_PLUS);
        o_cls.is_zero   = (i_in_data.ch == CH_ZERO);
        o_cls.is_x      = (i_in_data.ch == CH_UP_X) || (i_in_data.ch == CH_LO_X);
        o_cls.is_hex    = (digit < BASE_HEX);
    end

    // Accept while the queue has room
    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

endmodule

`default_nettype wire

>>> src/stu_queue.sv
// ----------------------------------------------------------------------------
// stu_queue - short queue of classified characters
// Decouples the front end from the converter so either side can stall.
// ----------------------------------------------------------------------------
`default_nettype none

module stu_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  stu_pkg::t_cls  i_cls,
    output logic           o_full,
    input  wire            i_pop,
    output logic           o_head_valid,
    output stu_pkg::t_cls  o_head
);
    import stu_pkg::*;

    localparam int CNT_W = QUEUE_AW + 1;

    t_cls               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [CNT_W-1:0]    r_count;

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Occupancy never exceeds the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    // Pop only from a non-empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> src/stu_back.sv
// ----------------------------------------------------------------------------
// stu_back - conversion engine
// Steps the parse state machine once per classified character, performs the
// multiply-add with overflow check and holds each result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stu_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_head_valid,
    input  stu_pkg::t_cls      i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    output stu_pkg::t_out_item o_out_data,
    input  wire                i_out_stall
);
    import stu_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > CONSUMED_W) ? COUNT_WIDTH : CONSUMED_W;
    localparam int PROD_W = VALUE_W + BASE_W;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_BLANK  = 6'b000010,
        PH_SIGNED = 6'b000100,
        PH_DIGITS = 6'b001000,
        PH_ZERO   = 6'b010000,
        PH_XSEEN  = 6'b100000
    } t_phase;

    // Saturating position increment
    function automatic logic [COUNT_WIDTH-1:0] cnt_inc(input logic [COUNT_WIDTH-1:0] v);
        begin
            return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
        end
    endfunction

    // Clamp a position to the result field
    function automatic logic [CONSUMED_W-1:0] cnt_sat(input logic [COUNT_WIDTH-1:0] v);
        logic [EXT_W-1:0] w;
        begin
            w = EXT_W'(v);
            return (w > EXT_W'({CONSUMED_W{1'b1}})) ? {CONSUMED_W{1'b1}}
                                                     : w[CONSUMED_W-1:0];
        end
    endfunction

    t_phase                 r_phase, n_phase;
    logic [VALUE_W-1:0]     r_acc, n_acc;
    logic                   r_neg, n_neg;
    logic                   r_ovf, n_ovf;
    logic                   r_any, n_any;
    logic [BASE_W-1:0]      r_base, n_base;
    logic [COUNT_WIDTH-1:0] r_pos, n_pos;
    logic [COUNT_WIDTH-1:0] r_zpos, n_zpos;
    logic                   r_out_valid;
    t_out_item              r_out_data;

    // Effective state after the start marker is applied
    t_phase                 ph_e;
    logic [VALUE_W-1:0]     acc_e;
    logic                   neg_e, ovf_e, any_e;
    logic [BASE_W-1:0]      base_e;
    logic [COUNT_WIDTH-1:0] pos_e, zpos_e;

    // Digit step operands and results
    logic                   fc_bad, fc_zero, first_path;
    logic [BASE_W-1:0]      ds_base;
    logic [VALUE_W-1:0]     ds_acc;
    logic                   ds_any;
    logic                   ds_end;
    logic [PROD_W-1:0]      prod;
    logic [PROD_W:0]        sum;
    t_out_item              ds_res;

    logic                   run_ds;
    logic                   emit;
    t_out_item              emit_data;

    assign o_pop = i_head_valid && (!r_out_valid || !i_out_stall);

    // Apply the start marker or advance the position
    always_comb begin
        ph_e   = r_phase;
        acc_e  = r_acc;
        neg_e  = r_neg;
        ovf_e  = r_ovf;
        any_e  = r_any;
        base_e = r_base;
        pos_e  = r_pos;
        zpos_e = r_zpos;
        if (i_head.start) begin
            ph_e   = PH_BLANK;
            acc_e  = '0;
            neg_e  = 1'b0;
            ovf_e  = 1'b0;
            any_e  = 1'b0;
            base_e = i_head.base;
            pos_e  = '0;
            zpos_e = '0;
        end else if (r_phase != PH_IDLE) begin
            pos_e = cnt_inc(r_pos);
        end
    end

    // Select the digit step operands
    always_comb begin
        fc_bad     = (base_e == BASE_INVALID) || (base_e > BASE_MAX);
        fc_zero    = ((base_e == BASE_AUTO) || (base_e == BASE_HEX)) && i_head.is_zero;
        first_path = ((ph_e == PH_BLANK) && !i_head.is_blank && !i_head.is_minus
                      && !i_head.is_plus) || (ph_e == PH_SIGNED);
        ds_base    = base_e;
        ds_acc     = acc_e;
        ds_any     = any_e;
        if (first_path && !fc_bad && !fc_zero) begin
            ds_base = (base_e == BASE_AUTO) ? BASE_DEC : base_e;
        end
        if ((ph_e == PH_XSEEN) && i_head.is_hex) begin
            ds_base = BASE_HEX;
            ds_acc  = '0;
            ds_any  = 1'b0;
        end
    end

    // Multiply-add and end-of-number result
    always_comb begin
        ds_end = (i_head.digit >= ds_base);
        prod   = PROD_W'(ds_acc) * PROD_W'(ds_base);
        sum    = (PROD_W + 1)'(prod) + (PROD_W + 1)'(i_head.digit);
        if (ovf_e) begin
            ds_res.value    = {VALUE_W{1'b1}};
            ds_res.consumed = cnt_sat(pos_e);
            ds_res.status   = ST_OVERFLOW;
        end else if (!ds_any) begin
            ds_res.value    = '0;
            ds_res.consumed = '0;
            ds_res.status   = ST_NO_CONV;
        end else begin
            ds_res.value    = neg_e ? (VALUE_W'(0) - ds_acc) : ds_acc;
            ds_res.consumed = cnt_sat(pos_e);
            ds_res.status   = ST_CONVERTED;
        end
    end

    // Parse state machine
    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_ovf     = r_ovf;
        n_any     = r_any;
        n_base    = r_base;
        n_pos     = r_pos;
        n_zpos    = r_zpos;
        run_ds    = 1'b0;
        emit      = 1'b0;
        emit_data = '0;
        if (o_pop) begin
            n_phase = ph_e;
            n_acc   = acc_e;
            n_neg   = neg_e;
            n_ovf   = ovf_e;
            n_any   = any_e;
            n_base  = base_e;
            n_pos   = pos_e;
            n_zpos  = zpos_e;
            case (ph_e)
                PH_BLANK, PH_SIGNED: begin
                    if ((ph_e == PH_BLANK) && i_head.is_blank) begin
                        n_phase = PH_BLANK;
                    end else if ((ph_e == PH_BLANK) && i_head.is_minus) begin
                        n_neg   = 1'b1;
                        n_phase = PH_SIGNED;
                    end else if ((ph_e == PH_BLANK) && i_head.is_plus) begin
                        n_phase = PH_SIGNED;
                    end else if (fc_bad) begin
                        emit             = 1'b1;
                        emit_data.value  = '0;
                        emit_data.consumed = '0;
                        emit_data.status = ST_NO_CONV;
                    end else if (fc_zero) begin
                        n_base  = (base_e == BASE_AUTO) ? BASE_OCT : base_e;
                        n_acc   = '0;
                        n_any   = 1'b1;
                        n_zpos  = pos_e;
                        n_phase = PH_ZERO;
                    end else begin
                        run_ds = 1'b1;
                    end
                end
                PH_ZERO: begin
                    if (i_head.is_x) begin
                        n_phase = PH_XSEEN;
                    end else begin
                        run_ds = 1'b1;
                    end
                end
                PH_XSEEN: begin
                    if (i_head.is_hex) begin
                        run_ds = 1'b1;
                    end else begin
                        emit               = 1'b1;
                        emit_data.value    = '0;
                        emit_data.consumed = cnt_sat(cnt_inc(zpos_e));
                        emit_data.status   = ST_CONVERTED;
                    end
                end
                PH_DIGITS: begin
                    run_ds = 1'b1;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
            // Take one digit, or finish the number
            if (run_ds) begin
                n_base  = ds_base;
                n_acc   = ds_acc;
                n_any   = ds_any;
                n_phase = PH_DIGITS;
                if (ds_end) begin
                    emit      = 1'b1;
                    emit_data = ds_res;
                end else begin
                    if (!ovf_e) begin
                        if (|sum[PROD_W:VALUE_W]) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = sum[VALUE_W-1:0];
                        end
                    end
                    n_any = 1'b1;
                end
            end
            if (emit) begin
                n_phase = PH_IDLE;
            end
        end
    end

    // Hold parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_ovf   <= 1'b0;
            r_any   <= 1'b0;
            r_base  <= BASE_AUTO;
            r_pos   <= '0;
            r_zpos  <= '0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_ovf   <= n_ovf;
            r_any   <= n_any;
            r_base  <= n_base;
            r_pos   <= n_pos;
            r_zpos  <= n_zpos;
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_data <= emit_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A new result only follows a dequeued character
    a_emit_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid && i_out_stall)) |-> $past(o_pop))
        else $error("result without a dequeued character");

    // Overflow results carry all ones
    a_ovf_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.status == ST_OVERFLOW)
            |-> (r_out_data.value == {VALUE_W{1'b1}}))
        else $error("overflow result not saturated");

    // No-conversion results are zero
    a_noconv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.status == ST_NO_CONV)
            |-> (r_out_data.value == '0 && r_out_data.consumed == '0))
        else $error("no-conversion result not cleared");

    // The parse ends whenever a result is produced
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && emit) |=> (r_phase == PH_IDLE))
        else $error("parse still active after result");

endmodule

`default_nettype wire

>>> src/string_to_unsigned_parser_unit.sv
// ----------------------------------------------------------------------------
// string_to_unsigned_parser_unit - character-stream to 32-bit unsigned parser
// Front end classifies characters, a four-entry queue decouples it from the
// conversion engine, which emits one result per string.
// ----------------------------------------------------------------------------
// Accepts one character per clock cycle while the queue has room: the
// conversion engine performs one 32 x 6 multiply-add with overflow check
// per character, and that single unit sets the throughput. The character
// that ends the number passes through the queue; when the engine dequeues
// it, the result is loaded into the output register. A four-entry queue
// between classifier and engine absorbs output stalls; requests are stalled
// once it is full. The base register is sampled with each start-of-string
// character. There is no clearing pass after reset.
`default_nettype none

module string_to_unsigned_parser_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  stu_pkg::t_in_item      i_in_data,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    output stu_pkg::t_out_item     o_out_data,
    input  wire                    i_out_stall,
    input  wire                    i_cfg_we,
    input  wire [5:0]              i_cfg_data
);
    import stu_pkg::*;

    t_cls push_cls;
    t_cls head_cls;
    logic push;
    logic full;
    logic pop;
    logic head_valid;

    // Classify requests
    stu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_full     (full),
        .o_push     (push),
        .o_cls      (push_cls)
    );

    // Queue classified characters
    stu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cls        (push_cls),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head_cls)
    );

    // Convert
    stu_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_cls),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule

`default_nettype wire
